FILE: rtl/rmst_pkg.sv
// Shared constants and types for the range-maximum segment tree core.
// Sizes of the node memory, index and value widths, and the controller states.
// No dependencies.
package rmst_pkg;

	// Largest number of leaves and the node store that covers them.
	localparam int MAX_ELEMENTS = 1024;
	localparam int NODE_COUNT   = 4 * MAX_ELEMENTS;

	// Widths of indexes, leaf counts, node addresses and values.
	localparam int IDX_W  = $clog2(MAX_ELEMENTS);
	localparam int CNT_W  = IDX_W + 1;
	localparam int NODE_W = $clog2(NODE_COUNT);
	localparam int VAL_W  = 64;

	// Request modes.
	localparam logic MODE_UPDATE = 1'b0;
	localparam logic MODE_QUERY  = 1'b1;

	// Value that every node holds after a clear.
	localparam logic signed [VAL_W-1:0] MOST_NEGATIVE = {1'b1, {(VAL_W-1){1'b0}}};

	// Controller states, one-hot.
	typedef enum logic [5:0] {
		S_CLEAR    = 6'b000001,
		S_IDLE     = 6'b000010,
		S_UPD_DOWN = 6'b000100,
		S_UPD_UP   = 6'b001000,
		S_QRY      = 6'b010000,
		S_QRY_DONE = 6'b100000
	} state_t;

endpackage

FILE: rtl/range_max_segment_tree_core.sv
// Range-maximum segment tree core: node memory, clear sweep, update and query sequencer.
// Depends on rmst_pkg for sizes, state encoding and the clear value.
//
//   Channel   Signals                                        Direction  Handshake
//   request   start, mode, index_low, index_high, new_value  in         start & !busy
//   result    done, max_value, range_error                   out        done, one cycle
//   config    cfg_we, cfg_wdata                              in         cfg_we
//
// An update walks down one tree level per cycle to its leaf, then climbs one level per
// cycle (sibling read, parent write). A query walks two paths one node per cycle
// through the single read port; a rejected query answers straight from idle with
// range_error set, and an update with an index out of range is ignored and leaves the
// core idle. After reset and after every config write the node memory is swept to the most
// negative value, one entry per cycle, with busy high. Results cannot be stalled: done
// marks a one-cycle result, and the next request may start in that cycle.
module range_max_segment_tree_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic                               mode,
	input  logic [rmst_pkg::IDX_W-1:0]         index_low,
	input  logic [rmst_pkg::IDX_W-1:0]         index_high,
	input  logic signed [rmst_pkg::VAL_W-1:0]  new_value,
	output logic                               done,
	output logic signed [rmst_pkg::VAL_W-1:0]  max_value,
	output logic                               range_error,
	input  logic                               cfg_we,
	input  logic [rmst_pkg::CNT_W-1:0]         cfg_wdata
);
	import rmst_pkg::*;

	// Node memory, one write port and one registered read port.
	logic signed [VAL_W-1:0] mem [NODE_COUNT];
	logic                    mem_we;
	logic [NODE_W-1:0]       wr_addr;
	logic signed [VAL_W-1:0] wr_data;
	logic                    rd_en;
	logic [NODE_W-1:0]       rd_addr;
	logic signed [VAL_W-1:0] rdata_s1;
	logic                    rd_v_s1;

	// Control state.
	state_t             state_q, state_d;
	logic [NODE_W-1:0]  clr_cnt_q, clr_cnt_d;
	logic [CNT_W-1:0]   leaves_q, leaves_d;
	logic               done_q, done_d;
	logic               pend_v_q, pend_v_d;

	// Walk registers.
	logic [IDX_W-1:0]        lo_q, lo_d, hi_q, hi_d, a_q, a_d, b_q, b_d;
	logic [NODE_W-1:0]       node_q, node_d;
	logic [IDX_W-1:0]        p_a_q, p_a_d, p_hi_q, p_hi_d, p_b_q, p_b_d;
	logic [NODE_W-1:0]       p_node_q, p_node_d;
	logic signed [VAL_W-1:0] acc_q, acc_d, cur_q, cur_d;
	logic signed [VAL_W-1:0] res_val_q, res_val_d;
	logic                    res_err_q, res_err_d;

	// Combinational helpers.
	logic [CNT_W-1:0]        ab_sum;
	logic [IDX_W-1:0]        mid;
	logic [NODE_W-1:0]       node_l, node_r, node_par, node_sib;
	logic                    full_cover;
	logic [CNT_W-1:0]        cfg_clamped;
	logic signed [VAL_W-1:0] rd_max_acc, rd_max_cur;
	logic                    accept;

	assign busy        = (state_q != S_IDLE);
	assign accept      = start && !busy;
	assign done        = done_q;
	assign max_value   = res_val_q;
	assign range_error = res_err_q;

	// Midpoint, child, parent and sibling addresses of the current node.
	assign ab_sum     = {1'b0, a_q} + {1'b0, b_q};
	assign mid        = ab_sum[CNT_W-1:1];
	assign node_l     = {node_q[NODE_W-2:0], 1'b1};
	assign node_r     = {node_q[NODE_W-2:0], 1'b0} + NODE_W'(2);
	assign node_par   = NODE_W'((node_q - NODE_W'(1)) >> 1);
	assign node_sib   = node_q[0] ? node_q + NODE_W'(1) : node_q - NODE_W'(1);
	assign full_cover = (lo_q == a_q) && (hi_q == b_q);
	assign rd_max_acc = (rdata_s1 > acc_q) ? rdata_s1 : acc_q;
	assign rd_max_cur = (rdata_s1 > cur_q) ? rdata_s1 : cur_q;

	// Leaf count seen by the tree: zero counts as one, large values saturate.
	always_comb begin
		if (cfg_wdata == '0) begin
			cfg_clamped = CNT_W'(1);
		end else if (cfg_wdata > CNT_W'(MAX_ELEMENTS)) begin
			cfg_clamped = CNT_W'(MAX_ELEMENTS);
		end else begin
			cfg_clamped = cfg_wdata;
		end
	end

	// Sequencer: clear sweep, update descent and climb, query walk.
	always_comb begin
		state_d   = state_q;
		clr_cnt_d = clr_cnt_q;
		leaves_d  = leaves_q;
		done_d    = 1'b0;
		pend_v_d  = pend_v_q;
		lo_d      = lo_q;
		hi_d      = hi_q;
		a_d       = a_q;
		b_d       = b_q;
		node_d    = node_q;
		p_a_d     = p_a_q;
		p_hi_d    = p_hi_q;
		p_b_d     = p_b_q;
		p_node_d  = p_node_q;
		acc_d     = rd_v_s1 ? rd_max_acc : acc_q;
		cur_d     = cur_q;
		res_val_d = res_val_q;
		res_err_d = res_err_q;
		mem_we    = 1'b0;
		wr_addr   = node_q;
		wr_data   = cur_q;
		rd_en     = 1'b0;
		rd_addr   = node_q;

		case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				wr_addr   = clr_cnt_q;
				wr_data   = MOST_NEGATIVE;
				clr_cnt_d = clr_cnt_q + NODE_W'(1);
				if (clr_cnt_q == NODE_W'(NODE_COUNT - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					lo_d     = index_low;
					hi_d     = index_high;
					a_d      = '0;
					b_d      = IDX_W'(leaves_q - CNT_W'(1));
					node_d   = '0;
					cur_d    = new_value;
					acc_d    = MOST_NEGATIVE;
					pend_v_d = 1'b0;
					if (mode == MODE_UPDATE) begin
						if ({1'b0, index_low} < leaves_q) begin
							state_d = S_UPD_DOWN;
						end
					end else if ((index_low > index_high) ||
							({1'b0, index_high} >= leaves_q)) begin
						done_d    = 1'b1;
						res_val_d = '0;
						res_err_d = 1'b1;
					end else begin
						state_d = S_QRY;
					end
				end
			end
			S_UPD_DOWN: begin
				if (a_q == b_q) begin
					// Leaf reached: write it, then start the climb unless the leaf is the root.
					mem_we  = 1'b1;
					wr_addr = node_q;
					wr_data = cur_q;
					if (node_q == '0) begin
						state_d = S_IDLE;
					end else begin
						rd_en   = 1'b1;
						rd_addr = node_sib;
						node_d  = node_par;
						state_d = S_UPD_UP;
					end
				end else if (lo_q <= mid) begin
					b_d    = mid;
					node_d = node_l;
				end else begin
					a_d    = mid + IDX_W'(1);
					node_d = node_r;
				end
			end
			S_UPD_UP: begin
				// Parent takes the larger of the climbing value and its sibling.
				mem_we  = 1'b1;
				wr_addr = node_q;
				wr_data = rd_max_cur;
				cur_d   = rd_max_cur;
				if (node_q == '0) begin
					state_d = S_IDLE;
				end else begin
					rd_en   = 1'b1;
					rd_addr = node_sib;
					node_d  = node_par;
				end
			end
			S_QRY: begin
				if (full_cover) begin
					// Node lies wholly inside the range: take it and end this path.
					rd_en   = 1'b1;
					rd_addr = node_q;
					if (pend_v_q) begin
						pend_v_d = 1'b0;
						lo_d     = p_a_q;
						a_d      = p_a_q;
						hi_d     = p_hi_q;
						b_d      = p_b_q;
						node_d   = p_node_q;
					end else begin
						state_d = S_QRY_DONE;
					end
				end else if (hi_q <= mid) begin
					b_d    = mid;
					node_d = node_l;
				end else if (lo_q > mid) begin
					a_d    = mid + IDX_W'(1);
					node_d = node_r;
				end else if (hi_q == b_q) begin
					// Right child fully covered: read it, continue left.
					rd_en   = 1'b1;
					rd_addr = node_r;
					hi_d    = mid;
					b_d     = mid;
					node_d  = node_l;
				end else if (lo_q == a_q) begin
					// Left child fully covered: read it, continue right.
					rd_en   = 1'b1;
					rd_addr = node_l;
					lo_d    = mid + IDX_W'(1);
					a_d     = mid + IDX_W'(1);
					node_d  = node_r;
				end else begin
					// First split with both sides partial: park the right path.
					pend_v_d = 1'b1;
					p_a_d    = mid + IDX_W'(1);
					p_hi_d   = hi_q;
					p_b_d    = b_q;
					p_node_d = node_r;
					hi_d     = mid;
					b_d      = mid;
					node_d   = node_l;
				end
			end
			S_QRY_DONE: begin
				done_d    = 1'b1;
				res_val_d = rd_max_acc;
				res_err_d = 1'b0;
				state_d   = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		// A register write reshapes the tree and restarts the sweep.
		if (cfg_we) begin
			leaves_d  = cfg_clamped;
			clr_cnt_d = '0;
			state_d   = S_CLEAR;
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			clr_cnt_q <= '0;
			leaves_q  <= CNT_W'(MAX_ELEMENTS);
			done_q    <= 1'b0;
			pend_v_q  <= 1'b0;
			rd_v_s1   <= 1'b0;
		end else begin
			state_q   <= state_d;
			clr_cnt_q <= clr_cnt_d;
			leaves_q  <= leaves_d;
			done_q    <= done_d;
			pend_v_q  <= pend_v_d;
			rd_v_s1   <= rd_en;
		end
	end

	// Walk and result payload registers.
	always_ff @(posedge clk) begin
		lo_q      <= lo_d;
		hi_q      <= hi_d;
		a_q       <= a_d;
		b_q       <= b_d;
		node_q    <= node_d;
		p_a_q     <= p_a_d;
		p_hi_q    <= p_hi_d;
		p_b_q     <= p_b_d;
		p_node_q  <= p_node_d;
		acc_q     <= acc_d;
		cur_q     <= cur_d;
		res_val_q <= res_val_d;
		res_err_q <= res_err_d;
	end

	// Node memory write port.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Node memory read port, registered.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_s1 <= mem[rd_addr];
		end
	end

	// The climb never reads the entry it writes in the same cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && rd_en) |-> (wr_addr != rd_addr))
		else $error("node memory read and write hit the same entry");

	// Final query cycle always has the last node read in flight.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_QRY_DONE) |-> rd_v_s1)
		else $error("query finished without its last node read");

	// A rejected query reports a zero maximum.
	assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && res_err_q) |-> (res_val_q == '0))
		else $error("range error with nonzero maximum");

	// A result follows only the end of a query walk or an accepted query request.
	assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> ($past(state_q == S_QRY_DONE) || $past(accept && (mode == MODE_QUERY))))
		else $error("result strobe without a query");

	// A register write always starts a clear sweep.
	assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> ((state_q == S_CLEAR) && (clr_cnt_q == '0)))
		else $error("config write did not restart the clear sweep");

endmodule
